/* rtl/trial_division_prime_test_top_macros.svh */
// ----------------------------------------------------------------------------
// trial division prime test assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH

// checked only while out of reset
`define TDPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TDPT_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// tdpt_pkg
// Types and constants shared by the trial division prime test block.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // default width of the tested value
    localparam int VALUE_WIDTH_DEF = 32;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/tdpt_div.sv */
// ----------------------------------------------------------------------------
// tdpt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_div #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,   // below 2**(VALUE_WIDTH-1)
    input  logic [VALUE_WIDTH-1:0] i_divisor,    // nonzero
    output tdpt_pkg::t_div_stat    o_stat,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [VALUE_WIDTH-1:0] o_remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [VALUE_WIDTH-1:0] r_den;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [VALUE_WIDTH-1:0] w_trial;
    logic                   w_fit;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem[VALUE_WIDTH-2:0], r_quo[VALUE_WIDTH-1]};
    assign w_fit   = (w_trial >= r_den);

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = CNT_W'(VALUE_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_fit ? (w_trial - r_den) : w_trial;
            n_quo = {r_quo[VALUE_WIDTH-2:0], w_fit};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_divisor;
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

/* rtl/trial_division_prime_test_top.sv */
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Trial division primality test on a shared sequential divider.
// ----------------------------------------------------------------------------
// Takes one signed value per transaction and returns 1 if it is prime, else 0.
// Negative values, zero and one give 0, two gives 1 and other even values give
// 0, each settled without any division and passed through S_DONE to the
// output register. An odd value of 3 or more is divided by 3, 5, 7, ... until
// a divisor leaves no remainder (not prime) or the divisor exceeds the
// quotient (prime). Every trial runs on one restoring divider that makes one
// quotient bit a cycle; composites stop at their smallest odd factor. The
// input is not ready while a value is under test; a result waits in an output
// register, and the next value is accepted only after the previous one has
// finished its trials and its verdict has moved into a free output register.
module trial_division_prime_test_top #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // [VALUE_WIDTH-1:0] candidate
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata   // [0] is_prime
);

    `include "trial_division_prime_test_top_macros.svh"

    tdpt_pkg::t_state       r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [VALUE_WIDTH-1:0] r_divisor, n_divisor;
    logic                   r_prime, n_prime;
    logic                   r_div_start, n_div_start;
    logic                   r_m_valid, n_m_valid;
    logic                   r_m_prime, n_m_prime;

    logic [VALUE_WIDTH-1:0] w_cand;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_early;
    logic                   w_early_prime;
    logic                   w_stop_prime;
    logic                   w_stop_comp;
    tdpt_pkg::t_div_stat    w_div_stat;
    logic [VALUE_WIDTH-1:0] w_quo;
    logic [VALUE_WIDTH-1:0] w_rem;

    assign w_cand     = s_tdata[VALUE_WIDTH-1:0];
    assign s_tready   = (r_state == tdpt_pkg::S_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_m_valid || m_tready;

    // values settled without any division
    always_comb begin
        w_early       = 1'b1;
        w_early_prime = 1'b0;
        if (w_cand[VALUE_WIDTH-1] || (w_cand <= VALUE_WIDTH'(1))) begin
            w_early_prime = 1'b0;
        end else if (w_cand == VALUE_WIDTH'(2)) begin
            w_early_prime = 1'b1;
        end else if (!w_cand[0]) begin
            w_early_prime = 1'b0;
        end else begin
            w_early = 1'b0;
        end
    end

    // trial outcome once the divider finishes
    assign w_stop_prime = w_div_stat.done && (r_divisor > w_quo);
    assign w_stop_comp  = w_div_stat.done && !(r_divisor > w_quo) && (w_rem == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdpt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_early ? tdpt_pkg::S_DONE : tdpt_pkg::S_DIV;
                end
            end
            tdpt_pkg::S_DIV: begin
                if (w_stop_prime || w_stop_comp) begin
                    n_state = tdpt_pkg::S_DONE;
                end
            end
            tdpt_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = tdpt_pkg::S_IDLE;
                end
            end
            default: n_state = tdpt_pkg::S_IDLE;
        endcase
    end

    // datapath and output register updates
    always_comb begin
        n_value     = r_value;
        n_divisor   = r_divisor;
        n_prime     = r_prime;
        n_div_start = 1'b0;
        n_m_valid   = r_m_valid && !m_tready;
        n_m_prime   = r_m_prime;
        case (r_state)
            tdpt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_value     = w_cand;
                    n_divisor   = VALUE_WIDTH'(3);
                    n_prime     = w_early_prime;
                    n_div_start = !w_early;
                end
            end
            tdpt_pkg::S_DIV: begin
                if (w_stop_prime) begin
                    n_prime = 1'b1;
                end else if (w_stop_comp) begin
                    n_prime = 1'b0;
                end else if (w_div_stat.done) begin
                    n_divisor   = r_divisor + VALUE_WIDTH'(2);
                    n_div_start = 1'b1;
                end
            end
            tdpt_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_prime = r_prime;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpt_pkg::S_IDLE;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_m_valid   <= n_m_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_divisor <= n_divisor;
        r_prime   <= n_prime;
        r_m_prime <= n_m_prime;
    end

    // shared divider
    tdpt_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_value),
        .i_divisor   (r_divisor),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {7'b0, r_m_prime};

    // checks
    `TDPT_ASSERT(a_div_idle_when_ready, s_tready |-> !w_div_stat.busy, "divider busy while ready")
    `TDPT_ASSERT(a_busy_after_accept, w_accept |=> !s_tready, "ready right after a transaction")
    `TDPT_ASSERT(a_done_in_div, w_div_stat.done |-> (r_state == tdpt_pkg::S_DIV), "stray done")
    `TDPT_ASSERT_ALL(a_start_no_overlap, r_div_start |-> !w_div_stat.busy, "divider restarted")

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for trial_division_prime_test_top. Streams directed
// edge values and random candidates through the slave port under varying
// backpressure, predicts each prime verdict and checks results in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int W                = tdpt_pkg::VALUE_WIDTH_DEF;
    localparam int DATA_W           = ((W + 7) / 8) * 8;
    // the largest prime below 2^31 needs the longest run of trials
    localparam int WATCHDOG_LIMIT   = 3_000_000;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int HOLD_OFF_CYCLES  = 600;
    localparam int DRAIN_CYCLES     = 16;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [W-1:0] candidate;
        logic         is_prime;
    } t_verdict;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // [W-1:0] candidate
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // [0] is_prime

    logic [W-1:0] pending_candidates [$];
    t_verdict     expected_verdicts [$];
    t_verdict     oldest_verdict;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_request;
    int           hold_left;
    bit           input_taken;
    int           quiet_cycles;
    int           mismatches;

    trial_division_prime_test_top #(
        .VALUE_WIDTH(W)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // odd trial divisors up to the square root, sign bit means not prime
    function automatic logic predict_is_prime(logic [W-1:0] cand);
        longint unsigned v;
        longint unsigned d;
        v = longint'(cand);
        if (cand[W-1])
            return 1'b0;
        if (v <= 1)
            return 1'b0;
        if (v == 2)
            return 1'b1;
        if (v % 2 == 0)
            return 1'b0;
        for (d = 3; d <= v / d; d += 2) begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly cheap values, a few wide ones that still stop early
    function automatic logic [W-1:0] random_candidate();
        int unsigned pick;
        int unsigned root;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return W'($urandom_range(0, 4095));
        end else if (pick < 70) begin
            return W'($urandom_range(0, 262143));
        end else if (pick < 80) begin
            // negative values
            return W'($urandom() | 32'h8000_0000);
        end else if (pick < 90) begin
            // wide positive multiples of three
            return W'($urandom_range(1, 715827882) * 3);
        end else if (pick < 95) begin
            // odd squares hit the divisor-equals-root boundary
            root = $urandom_range(1, 127) * 2 + 1;
            return W'(root * root);
        end else begin
            // wide even values
            return W'($urandom() & 32'hFFFF_FFFE);
        end
    endfunction

    // sender: new transaction at the falling edge, held until accepted
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || input_taken) begin
            input_taken = 1'b0;
            if (pending_candidates.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= DATA_W'(pending_candidates[0]);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: record accepted candidates, check results, watch for hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (s_tvalid && s_tready) begin
                expected_verdicts.push_back(
                    t_verdict'{candidate: s_tdata[W-1:0],
                               is_prime: predict_is_prime(s_tdata[W-1:0])});
                void'(pending_candidates.pop_front());
                input_taken  = 1'b1;
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                if (expected_verdicts.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: is_prime=%b", m_tdata[0]);
                    mismatches++;
                end else begin
                    oldest_verdict = expected_verdicts.pop_front();
                    if (m_tdata[0] !== oldest_verdict.is_prime) begin
                        if (mismatches < MAX_REPORTS)
                            $display("is_prime mismatch for %0d: expected %b, got %b",
                                     $signed(oldest_verdict.candidate),
                                     oldest_verdict.is_prime, m_tdata[0]);
                        mismatches++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [W-1:0] directed_values [20];
        int phase;
        int n;

        directed_values = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd49,
            32'd97, 32'd961, 32'd1021, 32'd65521, 32'd65535, 32'd65537,
            32'd999983, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE,
            32'h7FFF_FFFD, 32'h7FFF_FFFF
        };
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 57;
        hold_request  = 1'b0;
        hold_left     = 0;
        input_taken   = 1'b0;
        quiet_cycles  = 0;
        mismatches    = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed edge values
        foreach (directed_values[k])
            pending_candidates.push_back(directed_values[k]);
        while (pending_candidates.size() != 0)
            @(posedge i_clk);

        // random values under three stall mixes
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // back up the pipeline so the input stalls
                    hold_request  = 1'b1;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                pending_candidates.push_back(random_candidate());
            while (pending_candidates.size() != 0)
                @(posedge i_clk);
        end

        // drain
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
